// ===== design/mac_pdu_subheader_parser_assert.svh =====
// Assertion macros, compiled out when SYNTH is defined
`ifndef MAC_PDU_SUBHEADER_PARSER_ASSERT_SVH
`define MAC_PDU_SUBHEADER_PARSER_ASSERT_SVH

`ifndef SYNTH

`define MPS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

`define MPS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define MPS_ASSERT_IMP(label, clk, rst, ante, cons)

`define MPS_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/mps_pkg.sv =====
package mps_pkg;

   localparam int DEF_MAX_SDUS = 8;
   localparam int DEF_MAX_CES  = 8;

   localparam logic [4:0] LCID_FIRST_NON_SDU = 5'd25;
   localparam logic [4:0] LCID_PHR           = 5'd26;
   localparam logic [4:0] LCID_CRNTI         = 5'd27;
   localparam logic [4:0] LCID_TRUNC_BSR     = 5'd28;
   localparam logic [4:0] LCID_SHORT_BSR     = 5'd29;
   localparam logic [4:0] LCID_LONG_BSR      = 5'd30;
   localparam logic [4:0] LCID_PADDING       = 5'd31;

   localparam logic [1:0] KIND_SDU = 2'd0;
   localparam logic [1:0] KIND_CE  = 2'd1;
   localparam logic [1:0] KIND_PAD = 2'd2;

   typedef enum logic [1:0] {
      PHASE_FIXED   = 2'd0,
      PHASE_LEN     = 2'd1,
      PHASE_LEN_LSB = 2'd2
   } phase_type;

   typedef struct packed {
      logic [15:0] tb_len;
      logic [7:0]  header_byte;
   } item_type;

   typedef struct packed {
      logic [1:0]  entry_kind;
      logic [4:0]  channel_id;
      logic [15:0] sdu_length;
      logic [3:0]  sdu_total;
      logic [3:0]  ce_total;
      logic [15:0] header_size;
      logic        header_end;
      logic        overflow;
   } record_type;

   function automatic logic [1:0] ce_payload(input logic [4:0] lcid);
      logic [1:0] add;
      add = 2'd0;
      if (lcid == LCID_LONG_BSR) begin
         add = 2'd3;
      end else if (lcid == LCID_CRNTI) begin
         add = 2'd2;
      end else if (lcid == LCID_PHR || lcid == LCID_TRUNC_BSR || lcid == LCID_SHORT_BSR) begin
         add = 2'd1;
      end
      return add;
   endfunction

endpackage

// ===== design/mps_input_stage.sv =====
module mps_input_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,   // header_byte [7:0], tb_len [23:8]
   input  logic              advance,
   output logic              item_valid,
   output mps_pkg::item_type item
);
   import mps_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     req_accept;

   assign req_tready = !valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      item_in  = item_ff;
      valid_in = valid_ff;
      if (req_accept) begin
         item_in.header_byte = req_tdata[7:0];
         item_in.tb_len      = req_tdata[23:8];
         valid_in            = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== design/mps_parse.sv =====
`include "mac_pdu_subheader_parser_assert.svh"

module mps_parse #(
   parameter int MAX_SDUS = mps_pkg::DEF_MAX_SDUS,
   parameter int MAX_CES  = mps_pkg::DEF_MAX_CES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  mps_pkg::item_type   item,
   output logic                rec_valid,
   output mps_pkg::record_type rec
);
   import mps_pkg::*;

   localparam logic [3:0] MaxSdu = 4'(MAX_SDUS);
   localparam logic [3:0] MaxCe  = 4'(MAX_CES);

   phase_type   phase_ff, phase_in;
   logic [4:0]  held_lcid_ff, held_lcid_in;
   logic        held_end_ff, held_end_in;
   logic [6:0]  length_high_ff, length_high_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [15:0] payload_sum_ff, payload_sum_in;
   logic [3:0]  sdu_seen_ff, sdu_seen_in;
   logic [3:0]  ce_seen_ff, ce_seen_in;

   logic [7:0]  b;
   logic [4:0]  lcid;
   logic        last;
   logic [15:0] bc_inc;
   logic        sdu_ovf, ce_ovf;
   logic [3:0]  sdu_bump, ce_bump;
   logic [15:0] rec_len;

   assign b        = item.header_byte;
   assign lcid     = b[4:0];
   assign last     = !b[5];
   assign bc_inc   = (byte_count_ff == 16'hFFFF) ? byte_count_ff : byte_count_ff + 16'd1;
   assign sdu_ovf  = sdu_seen_ff >= MaxSdu;
   assign ce_ovf   = ce_seen_ff >= MaxCe;
   assign sdu_bump = sdu_ovf ? sdu_seen_ff : sdu_seen_ff + 4'd1;
   assign ce_bump  = ce_ovf ? ce_seen_ff : ce_seen_ff + 4'd1;

   always_comb begin
      phase_in       = phase_ff;
      held_lcid_in   = held_lcid_ff;
      held_end_in    = held_end_ff;
      length_high_in = length_high_ff;
      byte_count_in  = bc_inc;
      payload_sum_in = payload_sum_ff;
      sdu_seen_in    = sdu_seen_ff;
      ce_seen_in     = ce_seen_ff;
      rec_valid      = 1'b0;
      rec            = '0;
      rec_len        = '0;

      unique case (phase_ff)
         PHASE_LEN: begin
            if (!b[7]) begin
               rec_len          = {9'd0, b[6:0]};
               rec_valid        = 1'b1;
               rec.entry_kind   = KIND_SDU;
               rec.channel_id   = held_lcid_ff;
               rec.header_end   = !held_end_ff;
               rec.overflow     = sdu_ovf;
               sdu_seen_in      = sdu_bump;
               payload_sum_in   = payload_sum_ff + rec_len;
               phase_in         = PHASE_FIXED;
            end else begin
               length_high_in = b[6:0];
               phase_in       = PHASE_LEN_LSB;
            end
         end
         PHASE_LEN_LSB: begin
            rec_len        = {1'b0, length_high_ff, b};
            rec_valid      = 1'b1;
            rec.entry_kind = KIND_SDU;
            rec.channel_id = held_lcid_ff;
            rec.header_end = !held_end_ff;
            rec.overflow   = sdu_ovf;
            sdu_seen_in    = sdu_bump;
            payload_sum_in = payload_sum_ff + rec_len;
            phase_in       = PHASE_FIXED;
         end
         default: begin
            phase_in = PHASE_FIXED;
            if (lcid < LCID_FIRST_NON_SDU) begin
               if (last) begin
                  rec_len        = item.tb_len - bc_inc - payload_sum_ff;
                  rec_valid      = 1'b1;
                  rec.entry_kind = KIND_SDU;
                  rec.channel_id = lcid;
                  rec.header_end = 1'b1;
                  rec.overflow   = sdu_ovf;
                  sdu_seen_in    = sdu_bump;
                  payload_sum_in = payload_sum_ff + rec_len;
               end else begin
                  held_lcid_in = lcid;
                  held_end_in  = 1'b1;
                  phase_in     = PHASE_LEN;
               end
            end else if (lcid == LCID_PADDING) begin
               rec_valid      = 1'b1;
               rec.entry_kind = KIND_PAD;
               rec.channel_id = lcid;
               rec.header_end = last;
            end else begin
               rec_valid      = 1'b1;
               rec.entry_kind = KIND_CE;
               rec.channel_id = lcid;
               rec.header_end = last;
               rec.overflow   = ce_ovf;
               ce_seen_in     = ce_bump;
               payload_sum_in = payload_sum_ff + {14'd0, ce_payload(lcid)};
            end
         end
      endcase

      rec.sdu_length  = rec_len;
      rec.sdu_total   = sdu_seen_in;
      rec.ce_total    = ce_seen_in;
      rec.header_size = byte_count_in;

      // end of header: clear for the next PDU
      if (rec_valid && rec.header_end) begin
         phase_in       = PHASE_FIXED;
         held_lcid_in   = '0;
         held_end_in    = 1'b0;
         length_high_in = '0;
         byte_count_in  = '0;
         payload_sum_in = '0;
         sdu_seen_in    = '0;
         ce_seen_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_FIXED;
         held_lcid_ff   <= '0;
         held_end_ff    <= 1'b0;
         length_high_ff <= '0;
         byte_count_ff  <= '0;
         payload_sum_ff <= '0;
         sdu_seen_ff    <= '0;
         ce_seen_ff     <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         held_lcid_ff   <= held_lcid_in;
         held_end_ff    <= held_end_in;
         length_high_ff <= length_high_in;
         byte_count_ff  <= byte_count_in;
         payload_sum_ff <= payload_sum_in;
         sdu_seen_ff    <= sdu_seen_in;
         ce_seen_ff     <= ce_seen_in;
      end
   end

   `MPS_ASSERT_IMP(a_sdu_bound, clock, reset, 1'b1, sdu_seen_ff <= MaxSdu)
   `MPS_ASSERT_IMP(a_ce_bound, clock, reset, 1'b1, ce_seen_ff <= MaxCe)
   `MPS_ASSERT_IMP(a_len_held, clock, reset,
      phase_ff == PHASE_LEN || phase_ff == PHASE_LEN_LSB, held_end_ff)
   `MPS_ASSERT_NXT(a_end_clears, clock, reset, step && rec_valid && rec.header_end,
      byte_count_ff == 16'd0 && phase_ff == PHASE_FIXED)

endmodule

// ===== design/mps_output_stage.sv =====
module mps_output_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  mps_pkg::record_type rec,
   output logic                out_free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // channel_id [4:0], sdu_length [20:5], sdu_total [24:21], ce_total [28:25],
   // header_size [44:29], overflow [45], zero [47:46]
   output logic [47:0]         rsp_tdata,
   output logic                rsp_tlast,
   output logic [1:0]          rsp_tuser    // entry_kind [1:0]
);
   import mps_pkg::*;

   logic       valid_ff, valid_in;
   record_type rec_ff, rec_in;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      rec_in   = rec_ff;
      valid_in = valid_ff;
      if (load) begin
         rec_in   = rec;
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, rec_ff.overflow, rec_ff.header_size, rec_ff.ce_total,
                        rec_ff.sdu_total, rec_ff.sdu_length, rec_ff.channel_id};
   assign rsp_tlast  = rec_ff.header_end;
   assign rsp_tuser  = rec_ff.entry_kind;

endmodule

// ===== design/mac_pdu_subheader_parser.sv =====
// A header byte is held in the input register and its record in the output register.
// Throughput: one header byte per cycle unless rsp stalls; parse state updates per step.
// Stalls: a record held with rsp_tready low blocks the input register and req_tready.
// Reset: synchronous, active high; clears the parse state and both valid flags.
module mac_pdu_subheader_parser #(
   parameter int MAX_SDUS = mps_pkg::DEF_MAX_SDUS,
   parameter int MAX_CES  = mps_pkg::DEF_MAX_CES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // header_byte [7:0], tb_len [23:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // channel_id [4:0], sdu_length [20:5], sdu_total [24:21], ce_total [28:25],
   // header_size [44:29], overflow [45], zero [47:46]
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast,    // header_end
   output logic [1:0]  rsp_tuser     // entry_kind [1:0]
);
   import mps_pkg::*;

   logic       item_valid;
   item_type   item;
   logic       out_free;
   logic       step;
   logic       rec_valid;
   record_type rec;

   assign step = item_valid && out_free;

   mps_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (out_free),
      .item_valid (item_valid),
      .item       (item)
   );

   mps_parse #(
      .MAX_SDUS (MAX_SDUS),
      .MAX_CES  (MAX_CES)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (item),
      .rec_valid (rec_valid),
      .rec       (rec)
   );

   mps_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .load       (step && rec_valid),
      .rec        (rec),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import mps_pkg::*;

   localparam int STALL_LIMIT = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;

   mac_pdu_subheader_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   item_type   header_words[$];
   record_type expected_records[$];

   int words_sent = 0;
   int quiet_from = 0;
   int req_gap = 0;
   int rsp_hold = 0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int stall_cycles = 0;
   int mismatches = 0;
   int records_seen = 0;
   int sdu_records = 0;
   int ce_records = 0;
   int pad_records = 0;
   int end_records = 0;
   int ovf_records = 0;

   wire quiet = (words_sent >= quiet_from);

   // subheader parse state
   phase_type   parse_phase = PHASE_FIXED;
   logic [4:0]  held_channel = '0;
   logic [6:0]  len_msbs = '0;
   logic [15:0] hdr_bytes = '0;
   logic [15:0] ce_bytes = '0;
   logic [15:0] sdu_bytes = '0;
   logic [3:0]  sdu_cnt = '0;
   logic [3:0]  ce_cnt = '0;

   function automatic bit add_sdu(input logic [15:0] len);
      bit ovf;
      ovf = (sdu_cnt >= DEF_MAX_SDUS);
      if (!ovf) begin
         sdu_cnt = sdu_cnt + 4'd1;
      end
      sdu_bytes = sdu_bytes + len;
      return ovf;
   endfunction

   function automatic bit parse_byte(input item_type it, output record_type rec);
      logic [7:0]  b;
      logic [4:0]  lcid;
      logic [15:0] len;
      bit          got;
      b = it.header_byte;
      lcid = b[4:0];
      got = 1'b0;
      rec = '0;
      if (hdr_bytes != 16'hFFFF) begin
         hdr_bytes = hdr_bytes + 16'd1;
      end
      case (parse_phase)
         PHASE_LEN: begin
            if (b[7]) begin
               len_msbs = b[6:0];
               parse_phase = PHASE_LEN_LSB;
            end else begin
               len = {9'd0, b[6:0]};
               rec.entry_kind = KIND_SDU;
               rec.channel_id = held_channel;
               rec.sdu_length = len;
               rec.overflow = add_sdu(len);
               parse_phase = PHASE_FIXED;
               got = 1'b1;
            end
         end
         PHASE_LEN_LSB: begin
            len = {1'b0, len_msbs, b};
            rec.entry_kind = KIND_SDU;
            rec.channel_id = held_channel;
            rec.sdu_length = len;
            rec.overflow = add_sdu(len);
            parse_phase = PHASE_FIXED;
            got = 1'b1;
         end
         default: begin
            parse_phase = PHASE_FIXED;
            rec.channel_id = lcid;
            rec.header_end = !b[5];
            got = 1'b1;
            if (lcid < LCID_FIRST_NON_SDU) begin
               rec.entry_kind = KIND_SDU;
               if (b[5]) begin
                  held_channel = lcid;
                  parse_phase = PHASE_LEN;
                  got = 1'b0;
               end else begin
                  len = it.tb_len - hdr_bytes - ce_bytes - sdu_bytes;
                  rec.sdu_length = len;
                  rec.overflow = add_sdu(len);
               end
            end else if (lcid == LCID_PADDING) begin
               rec.entry_kind = KIND_PAD;
            end else begin
               rec.entry_kind = KIND_CE;
               if (ce_cnt >= DEF_MAX_CES) begin
                  rec.overflow = 1'b1;
               end else begin
                  ce_cnt = ce_cnt + 4'd1;
               end
               case (lcid)
                  LCID_LONG_BSR: ce_bytes = ce_bytes + 16'd3;
                  LCID_CRNTI: ce_bytes = ce_bytes + 16'd2;
                  LCID_PHR, LCID_TRUNC_BSR, LCID_SHORT_BSR: ce_bytes = ce_bytes + 16'd1;
                  default: ;
               endcase
            end
         end
      endcase
      if (got) begin
         rec.sdu_total = sdu_cnt;
         rec.ce_total = ce_cnt;
         rec.header_size = hdr_bytes;
         if (rec.header_end) begin
            parse_phase = PHASE_FIXED;
            held_channel = '0;
            len_msbs = '0;
            hdr_bytes = '0;
            ce_bytes = '0;
            sdu_bytes = '0;
            sdu_cnt = '0;
            ce_cnt = '0;
         end
      end
      return got;
   endfunction

   function automatic string record_text(input record_type r);
      return $sformatf("kind=%0d ch=%0d len=%0d sdus=%0d ces=%0d size=%0d end=%0d ovf=%0d",
                       r.entry_kind, r.channel_id, r.sdu_length, r.sdu_total,
                       r.ce_total, r.header_size, r.header_end, r.overflow);
   endfunction

   function automatic int idle_mix();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 15;
         default: return 40;
      endcase
   endfunction

   task automatic put_byte(input logic [7:0] b, input logic [15:0] tb);
      item_type it;
      it.header_byte = b;
      it.tb_len = tb;
      header_words.push_back(it);
   endtask

   // sdu_w out of 10 picks an SDU subheader; the rest split 3:1 control/padding
   task automatic add_pdu(input int subs, input int sdu_w);
      logic [15:0] tb;
      logic [4:0]  lcid;
      logic [1:0]  rr;
      bit          more;
      int          pick;
      int          k;
      tb = 16'($urandom);
      for (k = 0; k < subs; k++) begin
         more = (k != subs - 1);
         rr = 2'($urandom);
         pick = $urandom_range(0, 39);
         if (pick < 4 * sdu_w) begin
            lcid = 5'($urandom_range(0, LCID_FIRST_NON_SDU - 1));
            put_byte({rr, more, lcid}, tb);
            if (more) begin
               if ($urandom_range(0, 1) == 0) begin
                  put_byte({1'b0, 7'($urandom)}, tb);
               end else begin
                  put_byte({1'b1, 7'($urandom)}, tb);
                  put_byte(8'($urandom), tb);
               end
            end
         end else if ($urandom_range(0, 3) != 0) begin
            lcid = 5'($urandom_range(LCID_FIRST_NON_SDU, LCID_LONG_BSR));
            put_byte({rr, more, lcid}, tb);
         end else begin
            put_byte({rr, more, LCID_PADDING}, tb);
         end
      end
   endtask

   always @(posedge clock) begin
      if ($urandom_range(0, 79) == 0) begin
         req_idle_pct <= idle_mix();
      end
      if ($urandom_range(0, 79) == 0) begin
         rsp_stall_pct <= idle_mix();
      end
   end

   always @(posedge clock) begin : drive_proc
      record_type rec;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (parse_byte(item_type'(req_tdata), rec)) begin
               expected_records.push_back(rec);
            end
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (header_words.size() != 0) begin
               req_tdata <= header_words.pop_front();
               req_tvalid <= 1'b1;
               words_sent <= words_sent + 1;
               if (!quiet && $urandom_range(0, 99) < req_idle_pct) begin
                  req_gap <= $urandom_range(1, 7);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_proc
      record_type got;
      record_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.entry_kind = rsp_tuser;
            got.channel_id = rsp_tdata[4:0];
            got.sdu_length = rsp_tdata[20:5];
            got.sdu_total = rsp_tdata[24:21];
            got.ce_total = rsp_tdata[28:25];
            got.header_size = rsp_tdata[44:29];
            got.overflow = rsp_tdata[45];
            got.header_end = rsp_tlast;
            records_seen <= records_seen + 1;
            if (expected_records.size() == 0) begin
               if (mismatches < 10) begin
                  $display("record %0d arrived with nothing pending: %s", records_seen,
                           record_text(got));
               end
               mismatches <= mismatches + 1;
            end else begin
               want = expected_records.pop_front();
               if (got !== want) begin
                  if (mismatches < 10) begin
                     $display("record %0d expected %s", records_seen, record_text(want));
                     $display("record %0d actual   %s", records_seen, record_text(got));
                  end
                  mismatches <= mismatches + 1;
               end
               case (want.entry_kind)
                  KIND_SDU: sdu_records <= sdu_records + 1;
                  KIND_CE: ce_records <= ce_records + 1;
                  default: pad_records <= pad_records + 1;
               endcase
               if (want.header_end) begin
                  end_records <= end_records + 1;
               end
               if (want.overflow) begin
                  ovf_records <= ovf_records + 1;
               end
            end
         end
         if (rsp_hold != 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_hold <= $urandom_range(0, 6);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("no word moved for %0d cycles", STALL_LIMIT);
         $display("mac_pdu_subheader_parser: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      int          base;
      int          k;
      // implicit length at both tb_len extremes, reserved bits set
      put_byte(8'h00, 16'h0000);
      put_byte(8'hD8, 16'hFFFF);
      // short and long length forms at their limits, length sum wraps
      put_byte(8'h21, 16'($urandom));
      put_byte(8'h7F, 16'($urandom));
      put_byte(8'h38, 16'($urandom));
      put_byte(8'hFF, 16'($urandom));
      put_byte(8'hFF, 16'($urandom));
      put_byte(8'h22, 16'($urandom));
      put_byte(8'hFF, 16'($urandom));
      put_byte(8'hFF, 16'($urandom));
      put_byte(8'h23, 16'($urandom));
      put_byte(8'h80, 16'($urandom));
      put_byte(8'h00, 16'($urandom));
      put_byte(8'h24, 16'($urandom));
      put_byte(8'h00, 16'($urandom));
      // every control element and padding with more subheaders following
      for (k = LCID_FIRST_NON_SDU; k <= LCID_PADDING; k++) begin
         put_byte({3'b001, 5'(k)}, 16'($urandom));
      end
      put_byte(8'h05, 16'h1234);
      // control element and padding closing the header
      put_byte({3'b000, LCID_LONG_BSR}, 16'($urandom));
      put_byte({3'b110, LCID_PADDING}, 16'($urandom));

      base = header_words.size();
      while (header_words.size() < base + 370) begin
         k = $urandom_range(0, 9);
         if (k < 6) begin
            add_pdu($urandom_range(1, 6), 6);
         end else if (k < 8) begin
            case ($urandom_range(0, 2))
               0: add_pdu($urandom_range(9, 14), 10);
               1: add_pdu($urandom_range(9, 14), 0);
               default: add_pdu($urandom_range(9, 14), 6);
            endcase
         end else begin
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom), 16'($urandom));
         end
      end

      // closing stretch without idling on either side
      quiet_from = header_words.size();
      repeat (12) add_pdu($urandom_range(1, 6), 6);
      base = header_words.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock); while (header_words.size() != 0 || req_tvalid);
      do @(negedge clock); while (expected_records.size() != 0);
      repeat (8) @(negedge clock);

      $display("drove %0d header bytes, checked %0d records: %0d sdu, %0d control, %0d padding",
               base, records_seen, sdu_records, ce_records, pad_records);
      $display("%0d headers closed, %0d records flagged overflow",
               end_records, ovf_records);
      if (mismatches == 0 && expected_records.size() == 0) begin
         $display("mac_pdu_subheader_parser: match");
      end else begin
         $display("mac_pdu_subheader_parser: mismatch");
      end
      $finish;
   end

endmodule
